// ----- rtl/pcmr_pkg.sv -----
// Package with the shared types, constants and helper functions of the PCM ring FIFO.
`timescale 1ns / 1ps
`default_nettype none

package pcmr_pkg;

    // Storage geometry and field widths.
    localparam int DEPTH    = 1024;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int SW       = 16;
    localparam int CNT_W    = 64;
    localparam int MODE_W   = 2;
    localparam int S_DATA_W = 16;
    localparam int M_FLDS_W = SW + 1 + CW + 5 * CNT_W;
    localparam int M_DATA_W = ((M_FLDS_W + 7) / 8) * 8;

    localparam logic [CW-1:0] CAP_RESET = CW'(DEPTH);
    localparam logic [CW-1:0] CAP_MAX   = CW'(DEPTH);
    localparam logic [CW-1:0] CAP_MIN   = CW'(1);

    // Operation codes carried on the input tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_RESET = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Access request from the controller to the sample store.
    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [SW-1:0] wr_data;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
    } store_req_t;

    // Saturating increment of a lifetime counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (&v) ? v : v + CNT_W'(1);
    endfunction

    // Fold an index that may exceed the capacity by less than one capacity.
    function automatic logic [CW-1:0] wrap_idx(input logic [CW:0] i,
                                               input logic [CW-1:0] cap);
        logic [CW:0] diff;
        diff = i - {1'b0, cap};
        wrap_idx = (i >= {1'b0, cap}) ? diff[CW-1:0] : i[CW-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pcmr_store.sv -----
// Sample store of the PCM ring: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pcmr_store
    import pcmr_pkg::*;
(
    input  wire logic       aclk,
    input  wire store_req_t req,
    output logic [SW-1:0]   rd_data
);

    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port; the data register holds its value until the next read.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/pcm_ring_fifo_drop_oldest.sv -----
// Top level of the PCM ring FIFO that drops the oldest frame when full.
// Throughput: one word per cycle unless m_tready stalls the output; the store
// read issued in the accept cycle returns into a pending stage, then into the
// output register.
// Reset (aresetn low, synchronous) empties the ring, clears all five counters
// and sets capacity to 1024; the sample store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module pcm_ring_fifo_drop_oldest
    import pcmr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Capacity register.
    input  wire logic                cfg_wr_en,
    input  wire logic [CW-1:0]       cfg_wr_data,
    // Input channel.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [15:0] sample_in
    input  wire logic [MODE_W-1:0]   s_tuser,   // [1:0] mode
    // Result channel.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [15:0] sample_out, [16] dropped_now, [27:17] queue_depth,
    // [91:28] submitted_total, [155:92] dropped_total, [219:156] consumed_total,
    // [283:220] silence_total, [347:284] reset_total, [351:348] zero
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tuser    // [0] from_queue
);

    // Ring state and counters.
    logic [CW-1:0]    capacity_reg;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0] submitted_reg, submitted_next;
    logic [CNT_W-1:0] dropped_reg, dropped_next;
    logic [CNT_W-1:0] consumed_reg, consumed_next;
    logic [CNT_W-1:0] silence_reg, silence_next;
    logic [CNT_W-1:0] resets_reg, resets_next;

    // Pending stage: waits for the store read data.
    logic pend_valid_reg;
    logic pend_from_q_reg, pend_from_q_next;
    logic pend_drop_reg, pend_drop_next;

    // Output register.
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_user_reg;

    logic       accept;
    logic       move;
    mode_t      mode;
    store_req_t req;
    logic [SW-1:0] rd_data;
    logic [SW-1:0] sample_sel;

    logic [CW-1:0] cap;
    logic [CW-1:0] head_c;
    logic [CW-1:0] fill_c;
    logic [CW-1:0] head_inc;
    logic [CW-1:0] head_w;
    logic [CW-1:0] fill_w;
    logic [CW-1:0] wr_idx;

    assign mode     = mode_t'(s_tuser);
    assign move     = pend_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !pend_valid_reg || move;
    assign accept   = s_tvalid && s_tready;

    // Effective capacity and pointers kept inside it.
    always_comb begin
        if (capacity_reg == '0) begin
            cap = CAP_MIN;
        end else if (capacity_reg > CAP_MAX) begin
            cap = CAP_MAX;
        end else begin
            cap = capacity_reg;
        end
        head_c   = ({1'b0, head_reg} >= cap) ? '0 : {1'b0, head_reg};
        fill_c   = (fill_reg > cap) ? cap : fill_reg;
        head_inc = wrap_idx({1'b0, head_c} + (CW + 1)'(1), cap);
    end

    // Next state of the ring for the word being accepted.
    always_comb begin
        head_w         = head_c;
        fill_w         = fill_c;
        wr_idx         = '0;
        head_next      = head_c[AW-1:0];
        fill_next      = fill_c;
        submitted_next = submitted_reg;
        dropped_next   = dropped_reg;
        consumed_next  = consumed_reg;
        silence_next   = silence_reg;
        resets_next    = resets_reg;
        pend_from_q_next = 1'b0;
        pend_drop_next   = 1'b0;
        req.wr_en   = 1'b0;
        req.wr_addr = '0;
        req.wr_data = s_tdata[SW-1:0];
        req.rd_en   = 1'b0;
        req.rd_addr = head_c[AW-1:0];

        case (mode)
            MODE_WRITE: begin
                // A full ring gives up its oldest frame first.
                if (fill_c >= cap) begin
                    head_w         = head_inc;
                    fill_w         = fill_c - CW'(1);
                    pend_drop_next = 1'b1;
                    dropped_next   = sat_inc(dropped_reg);
                end
                wr_idx         = wrap_idx({1'b0, head_w} + {1'b0, fill_w}, cap);
                req.wr_en      = accept;
                req.wr_addr    = wr_idx[AW-1:0];
                head_next      = head_w[AW-1:0];
                fill_next      = fill_w + CW'(1);
                submitted_next = sat_inc(submitted_reg);
            end
            MODE_READ: begin
                // Read the oldest frame, or answer silence on an empty ring.
                if (fill_c != '0) begin
                    req.rd_en        = accept;
                    head_next        = head_inc[AW-1:0];
                    fill_next        = fill_c - CW'(1);
                    pend_from_q_next = 1'b1;
                    consumed_next    = sat_inc(consumed_reg);
                end else begin
                    silence_next = sat_inc(silence_reg);
                end
            end
            MODE_RESET: begin
                head_next   = '0;
                fill_next   = '0;
                resets_next = sat_inc(resets_reg);
            end
            MODE_CLEAR: begin
                head_next = '0;
                fill_next = '0;
            end
            default: begin
                head_next = '0;
                fill_next = '0;
            end
        endcase
    end

    pcmr_store u_store (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    // Ring state, counters and capacity.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= CAP_RESET;
            head_reg      <= '0;
            fill_reg      <= '0;
            submitted_reg <= '0;
            dropped_reg   <= '0;
            consumed_reg  <= '0;
            silence_reg   <= '0;
            resets_reg    <= '0;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
            head_reg     <= '0;
            fill_reg     <= '0;
        end else if (accept) begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            submitted_reg <= submitted_next;
            dropped_reg   <= dropped_next;
            consumed_reg  <= consumed_next;
            silence_reg   <= silence_next;
            resets_reg    <= resets_next;
        end
    end

    // Pending stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (accept) begin
            pend_valid_reg <= 1'b1;
        end else if (move) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_from_q_reg <= pend_from_q_next;
            pend_drop_reg   <= pend_drop_next;
        end
    end

    // The counters and depth still describe the pending word when it moves on.
    assign sample_sel = pend_from_q_reg ? rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_data_reg <= M_DATA_W'({resets_reg, silence_reg, consumed_reg,
                                       dropped_reg, submitted_reg, fill_reg,
                                       pend_drop_reg, sample_sel});
            out_user_reg <= pend_from_q_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // A word never both returns a queued frame and reports a drop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && m_tdata[SW]))
        else $error("from_queue and dropped_now set together");

    // Silence and non-read words carry a zero sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[SW-1:0] == '0))
        else $error("nonzero sample without a queued frame");

    // The fill level never exceeds the effective capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= cap)
        else $error("fill level above capacity");

    // A pending word that cannot move is neither lost nor replaced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !move) |=>
            (pend_valid_reg && $stable(pend_from_q_reg) && $stable(pend_drop_reg)))
        else $error("pending word overwritten");

endmodule

`default_nettype wire
